/* design/ppte_pkg.sv */
`timescale 1ns / 1ps
// Shared codes, widths and controller/datapath interface types for the trajectory evaluator.
package ppte_pkg;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 6;
   localparam int WORD_W     = 32;
   localparam int CSR_W      = 5;
   localparam int SEG_OUT_W  = 4;
   localparam int STEP_W     = 3;
   localparam int TDATA_W    = 72;

   localparam logic [OP_W-1:0] OP_WR_BREAK = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_COEFF = 2'd1;
   localparam logic [OP_W-1:0] OP_EVAL     = 2'd2;

   localparam logic [CSR_W-1:0] POINTS_RESET = 5'd3;

   // controller -> datapath
   typedef struct packed {
      logic              start;      // evaluate item taken: latch time, restart search
      logic              wr_break;   // breakpoint write item taken
      logic              wr_coeff;   // coefficient write item taken
      logic              rd_last;    // address the last breakpoint
      logic              chk_last;   // compare time against last breakpoint
      logic              scan_adv;   // step to next segment
      logic              scan_stop;  // segment found, form time offset
      logic              lead;       // load leading coefficient
      logic              cld;        // latch coefficient, start position product
      logic              rndp;       // start velocity product
      logic              accp;       // position accumulate
      logic              accv;       // velocity accumulate
      logic              load_rsp;   // move results into output register
      logic [STEP_W-1:0] step;       // Horner step number
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_hit;  // time <= breakpoint just read
      logic seg_last;  // current segment is the last one
      logic quartic;   // current segment has five coefficients
   } status_type;

endpackage

/* design/ppte_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for segment search and shared-multiplier Horner evaluation.
module ppte_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic [ppte_pkg::OP_W-1:0]      req_op,
   output logic                           req_tready,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   input  ppte_pkg::status_type           status,
   output ppte_pkg::cmd_type              cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LAST  = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_FETCH = 4'd3;
   localparam logic [3:0] ST_LEAD  = 4'd4;
   localparam logic [3:0] ST_CLD   = 4'd5;
   localparam logic [3:0] ST_RNDP  = 4'd6;
   localparam logic [3:0] ST_ACCP  = 4'd7;
   localparam logic [3:0] ST_ACCV  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic [ppte_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ppte_pkg::STEP_W-1:0]   last_step;

   assign last_step  = status.quartic ? 3'd4 : 3'd3;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.rd_last = 1'b1;
            if (req_tvalid) begin
               unique case (req_op)
                  ppte_pkg::OP_WR_BREAK: cmd.wr_break = 1'b1;
                  ppte_pkg::OP_WR_COEFF: cmd.wr_coeff = 1'b1;
                  ppte_pkg::OP_EVAL: begin
                     cmd.start = 1'b1;
                     step_in   = '0;
                     state_in  = ST_LAST;
                  end
                  default: ;
               endcase
            end
         end
         ST_LAST: begin
            cmd.chk_last = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_hit || status.seg_last) begin
               cmd.scan_stop = 1'b1;
               state_in      = ST_FETCH;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = (step_ff == '0) ? ST_LEAD : ST_CLD;
         end
         ST_LEAD: begin
            cmd.lead = 1'b1;
            step_in  = 3'd1;
            state_in = ST_FETCH;
         end
         ST_CLD: begin
            cmd.cld  = 1'b1;
            state_in = ST_RNDP;
         end
         ST_RNDP: begin
            cmd.rndp = 1'b1;
            state_in = ST_ACCP;
         end
         ST_ACCP: begin
            cmd.accp = 1'b1;
            state_in = ST_ACCV;
         end
         ST_ACCV: begin
            // velocity has one term fewer: its last step is skipped
            if (step_ff == last_step) begin
               state_in = ST_DONE;
            end else begin
               cmd.accv = 1'b1;
               step_in  = step_ff + 3'd1;
               state_in = ST_CLD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/ppte_datapath.sv */
`timescale 1ns / 1ps
// Breakpoint and coefficient stores, segment search compare and Horner arithmetic.
module ppte_datapath #(
   parameter int MAX_POINTS  = 16,
   parameter int COEFF_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [ppte_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [ppte_pkg::INDEX_W-1:0]          req_index,
   input  logic [ppte_pkg::WORD_W-1:0]           req_write_value,
   input  logic [ppte_pkg::WORD_W-1:0]           req_sample_time,
   input  ppte_pkg::cmd_type                     cmd,
   output ppte_pkg::status_type                  status,
   output logic [ppte_pkg::WORD_W-1:0]           rsp_position,
   output logic [ppte_pkg::WORD_W-1:0]           rsp_velocity,
   output logic [ppte_pkg::SEG_OUT_W-1:0]        rsp_segment,
   output logic                                  rsp_past_end
);

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(COEFF_DEPTH);
   localparam int CAW = CW + 1;

   // round(p / 2^16), ties away from zero
   function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
      logic signed [63:0] b;
      b = p + (p[63] ? 64'sd32767 : 64'sd32768);
      return b[63:16];
   endfunction

   function automatic logic [31:0] sat49(input logic signed [48:0] v);
      logic [31:0] r;
      if (v[48:31] == {18{v[48]}}) begin
         r = v[31:0];
      end else begin
         r = v[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      logic [31:0] r;
      if (v[33:31] == {3{v[33]}}) begin
         r = v[31:0];
      end else begin
         r = v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   logic [31:0] bp_mem    [MAX_POINTS];
   logic [31:0] coeff_mem [COEFF_DEPTH];

   logic [ppte_pkg::CSR_W-1:0] points_ff;
   logic [31:0]                bp_rd_ff, coeff_rd_ff;
   logic [31:0]                time_ff, lower_ff;
   logic [PW-1:0]              seg_ff, seg_in;
   logic [CW-1:0]              caddr_ff, caddr_in;
   logic                       past_end_ff;
   logic signed [31:0]         dt_ff, acc_pos_ff, acc_vel_ff, c_ff;
   logic signed [34:0]         cm_ff;
   logic signed [63:0]         prod_ff;
   logic signed [47:0]         rnd_ff;
   logic [31:0]                pos_out_ff, vel_out_ff;
   logic [ppte_pkg::SEG_OUT_W-1:0] seg_out_ff;
   logic                       past_out_ff;

   logic [7:0]          pts_ext, n8;
   logic [PW-1:0]       n_m1, n_m2, bp_addr;
   logic                bp_ok, coeff_ok;
   logic signed [32:0]  time33, bp33;
   logic signed [33:0]  off34;
   logic [31:0]         dt_in;
   logic [CAW-1:0]      csum, cstep;
   logic [2:0]          mult;
   logic signed [34:0]  c35, cm_now;
   logic signed [63:0]  mul_a, mul_b;

   // points in use, clamped to 3..MAX_POINTS
   assign pts_ext = {3'b000, points_ff};
   always_comb begin
      if (pts_ext < 8'd3) begin
         n8 = 8'd3;
      end else if (pts_ext > 8'(MAX_POINTS)) begin
         n8 = 8'(MAX_POINTS);
      end else begin
         n8 = pts_ext;
      end
   end
   assign n_m1 = PW'(n8 - 8'd1);
   assign n_m2 = PW'(n8 - 8'd2);

   assign bp_ok    = {2'b00, req_index} < 8'(MAX_POINTS);
   assign coeff_ok = {3'b000, req_index} < 9'(COEFF_DEPTH);

   always_comb begin
      if (cmd.start) begin
         seg_in = '0;
      end else if (cmd.scan_adv) begin
         seg_in = seg_ff + PW'(1);
      end else begin
         seg_in = seg_ff;
      end
   end
   assign bp_addr = cmd.rd_last ? n_m1 : seg_in + PW'(1);

   // unsigned time against signed breakpoint
   assign time33 = {1'b0, time_ff};
   assign bp33   = {bp_rd_ff[31], bp_rd_ff};

   assign status.scan_hit = (time33 <= bp33);
   assign status.seg_last = (seg_ff == n_m2);
   assign status.quartic  = (seg_ff == '0) || (seg_ff == n_m2);

   assign off34 = $signed({2'b00, time_ff}) - $signed({{2{lower_ff[31]}}, lower_ff});
   always_comb begin
      if (seg_ff == '0) begin
         dt_in = time_ff[31] ? 32'h7FFF_FFFF : time_ff;
      end else begin
         dt_in = sat34(off34);
      end
   end

   // coefficient address: segment s starts at 4s+1 (segment 0 at 0), wraps at depth
   always_comb begin
      cstep = (seg_ff == '0) ? CAW'(5) : CAW'(4);
      if (cmd.lead || cmd.cld) begin
         cstep = CAW'(1);
      end
      csum = {1'b0, caddr_ff} + cstep;
      if (csum >= CAW'(COEFF_DEPTH)) begin
         csum = csum - CAW'(COEFF_DEPTH);
      end
      if (cmd.start) begin
         caddr_in = '0;
      end else if (cmd.scan_adv || cmd.lead || cmd.cld) begin
         caddr_in = CW'(csum);
      end else begin
         caddr_in = caddr_ff;
      end
   end

   // derivative weight k * c for the term of power k
   assign mult   = (status.quartic ? 3'd4 : 3'd3) - cmd.step;
   assign c35    = 35'($signed(coeff_rd_ff));
   assign cm_now = c35 * $signed({32'd0, mult});

   assign mul_a = 64'(cmd.rndp ? acc_vel_ff : acc_pos_ff);
   assign mul_b = 64'(dt_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_break && bp_ok) begin
         bp_mem[PW'(req_index)] <= req_write_value;
      end
      bp_rd_ff <= bp_mem[bp_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_coeff && coeff_ok) begin
         coeff_mem[CW'(req_index)] <= req_write_value;
      end
      coeff_rd_ff <= coeff_mem[caddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= ppte_pkg::POINTS_RESET;
      end else if (csr_wen) begin
         points_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff   <= seg_in;
      caddr_ff <= caddr_in;
      prod_ff  <= mul_a * mul_b;
      rnd_ff   <= round_q16(prod_ff);
      if (cmd.start) begin
         time_ff <= req_sample_time;
      end
      if (cmd.chk_last) begin
         past_end_ff <= (time33 > bp33);
      end
      if (cmd.scan_adv) begin
         lower_ff <= bp_rd_ff;
      end
      if (cmd.scan_stop) begin
         dt_ff <= dt_in;
      end
      if (cmd.lead) begin
         acc_pos_ff <= coeff_rd_ff;
         acc_vel_ff <= sat49(49'(cm_now));
      end
      if (cmd.cld) begin
         c_ff  <= coeff_rd_ff;
         cm_ff <= cm_now;
      end
      if (cmd.accp) begin
         acc_pos_ff <= sat49(49'(rnd_ff) + 49'(c_ff));
      end
      if (cmd.accv) begin
         acc_vel_ff <= sat49(49'(rnd_ff) + 49'(cm_ff));
      end
      if (cmd.load_rsp) begin
         pos_out_ff  <= acc_pos_ff;
         vel_out_ff  <= acc_vel_ff;
         seg_out_ff  <= ppte_pkg::SEG_OUT_W'(seg_ff);
         past_out_ff <= past_end_ff;
      end
   end

   assign rsp_position = pos_out_ff;
   assign rsp_velocity = vel_out_ff;
   assign rsp_segment  = seg_out_ff;
   assign rsp_past_end = past_out_ff;

endmodule

/* design/piecewise_poly_trajectory_eval_top.sv */
`timescale 1ns / 1ps
// Top level of the 4-3-4 piecewise polynomial trajectory evaluator.
// Write items are taken straight from idle; an evaluate item gives its result after the
//   breakpoint scan and the Horner steps (terms 5 quartic, 4 cubic).
// No new item is taken while an evaluate runs; its length is set by the linear
//   breakpoint scan and the one shared 32x32 multiplier, used for position and velocity.
// Reset (synchronous, active high) idles the sequencer, empties the output register and
//   sets points_in_use to 3; breakpoint and coefficient stores are undefined until written.
module piecewise_poly_trajectory_eval_top #(
   parameter int MAX_POINTS  = 16,
   parameter int COEFF_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration: points_in_use
   input  logic                              csr_wen,
   input  logic [ppte_pkg::CSR_W-1:0]        csr_wdata,
   // request items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ppte_pkg::TDATA_W-1:0]      req_tdata,  // index[5:0], write_value[37:6],
                                                         // sample_time[69:38], zero pad
   input  logic [ppte_pkg::OP_W-1:0]         req_tuser,  // op[1:0]
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ppte_pkg::TDATA_W-1:0]      rsp_tdata,  // position[31:0], velocity[63:32],
                                                         // segment[67:64], zero pad
   output logic                              rsp_tuser   // past_end
);

   ppte_pkg::cmd_type    cmd;
   ppte_pkg::status_type status;

   logic [ppte_pkg::WORD_W-1:0]    position, velocity;
   logic [ppte_pkg::SEG_OUT_W-1:0] segment;

   // Controller: one item at a time; writes are taken straight from idle,
   // an evaluate runs search then Horner and parks its result in the output register.
   ppte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: stores, compare for the scan, offset saturation, multiplier,
   // rounding and saturating accumulate for position and velocity.
   ppte_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .COEFF_DEPTH (COEFF_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_index       (req_tdata[5:0]),
      .req_write_value (req_tdata[37:6]),
      .req_sample_time (req_tdata[69:38]),
      .cmd             (cmd),
      .status          (status),
      .rsp_position    (position),
      .rsp_velocity    (velocity),
      .rsp_segment     (segment),
      .rsp_past_end    (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, segment, velocity, position};

`ifndef SYNTHESIS
   // an evaluate item occupies the block: no new item right after it
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == ppte_pkg::OP_EVAL) |=> !req_tready)
      else $error("request taken while an evaluation is running");

   // write items finish in the cycle they are taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != ppte_pkg::OP_EVAL) |=> req_tready)
      else $error("write item stalled the request side");

   // a finished result always reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("result loaded but not presented");

   // a result is loaded only when the output register is empty or being taken, never over a pending one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && rsp_tvalid) |-> rsp_tready)
      else $error("pending result overwritten");
`endif

endmodule

/* bench/piecewise_poly_trajectory_eval_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 4-3-4 piecewise trajectory evaluator.
module piecewise_poly_trajectory_eval_top_tb;

   localparam int MAX_POINTS      = 16;
   localparam int COEFF_DEPTH     = 64;
   localparam int PW              = $clog2(MAX_POINTS);
   localparam int CW              = $clog2(COEFF_DEPTH);
   localparam int DIRECTED_N      = 25;
   localparam int PHASES          = 8;
   localparam int EVALS_PER_PHASE = 150;
   // wait after the last result, long enough for the longest evaluate, with some margin
   localparam int DRAIN_CYCLES    = 48;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   // spare op code, the block takes the item and does nothing with it
   localparam logic [ppte_pkg::OP_W-1:0] OP_SPARE = 2'd3;

   // one result item as the block presents it
   typedef struct packed {
      logic [ppte_pkg::WORD_W-1:0]    position;
      logic [ppte_pkg::WORD_W-1:0]    velocity;
      logic [ppte_pkg::SEG_OUT_W-1:0] segment;
      logic                           past_end;
   } traj_sample_type;

   // one request item; typed = 1 means the expected result is written in the row
   typedef struct packed {
      logic [ppte_pkg::OP_W-1:0]      op;
      logic [ppte_pkg::INDEX_W-1:0]   addr;
      logic [ppte_pkg::WORD_W-1:0]    value;
      logic [ppte_pkg::WORD_W-1:0]    when;
      logic                           typed;
      logic [ppte_pkg::WORD_W-1:0]    pos;
      logic [ppte_pkg::WORD_W-1:0]    vel;
      logic [ppte_pkg::SEG_OUT_W-1:0] seg;
      logic                           past;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wen;
   logic [ppte_pkg::CSR_W-1:0]     csr_wdata;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ppte_pkg::TDATA_W-1:0]   req_tdata;
   logic [ppte_pkg::OP_W-1:0]      req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ppte_pkg::TDATA_W-1:0]   rsp_tdata;
   logic                           rsp_tuser;

   // testbench copy of the block's state
   logic [ppte_pkg::WORD_W-1:0]    knot_times  [MAX_POINTS];
   logic [ppte_pkg::WORD_W-1:0]    poly_coeffs [COEFF_DEPTH];
   logic [ppte_pkg::CSR_W-1:0]     active_points = ppte_pkg::POINTS_RESET;

   traj_sample_type      pending_samples [$];
   int unsigned          mismatches      = 0;
   int unsigned          quiet_cycles    = 0;
   int unsigned          sender_idle_pct = 0;
   int unsigned          recv_stall_pct  = 0;
   bit                   hold_request    = 1'b0;

   piecewise_poly_trajectory_eval_top #(
      .MAX_POINTS (MAX_POINTS),
      .COEFF_DEPTH(COEFF_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // a * b / 2^16, rounded to nearest with ties away from zero
   function automatic longint mul_round(input longint a, input longint b);
      longint prod;
      longint mag;
      longint r;
      prod = a * b;
      mag  = (prod < 0) ? -prod : prod;
      r    = (mag + 64'sd32768) >>> 16;
      return (prod < 0) ? -r : r;
   endfunction

   function automatic int unsigned points_clamped(input logic [ppte_pkg::CSR_W-1:0] v);
      int unsigned n;
      n = v;
      if (n < 3) n = 3;
      if (n > MAX_POINTS) n = MAX_POINTS;
      return n;
   endfunction

   // Horner over the segment's coefficients, highest power first;
   // deriv scales each term by its power and drops the constant
   function automatic longint horner_sum(input int unsigned base, input int unsigned terms,
                                         input longint dt, input bit deriv);
      int unsigned count;
      longint      acc;
      longint      c;
      count = deriv ? terms - 1 : terms;
      acc   = 0;
      for (int unsigned k = 0; k < count; k++) begin
         c = longint'($signed(poly_coeffs[CW'((base + k) % COEFF_DEPTH)]));
         if (deriv) c = c * longint'(terms - 1 - k);
         if (k == 0) acc = sat_word(c);
         else acc = sat_word(mul_round(acc, dt) + c);
      end
      return acc;
   endfunction

   function automatic traj_sample_type predict_trajectory_sample(
         input logic [ppte_pkg::WORD_W-1:0] when);
      int unsigned     n;
      int unsigned     seg;
      int unsigned     base;
      int unsigned     terms;
      longint          t;
      longint          dt;
      traj_sample_type r;
      n   = points_clamped(active_points);
      t   = longint'({32'b0, when});
      // first breakpoint at or after the time picks the segment, signed compare
      seg = n - 2;
      for (int unsigned s = 0; s + 2 < n; s++) begin
         if (t <= longint'($signed(knot_times[PW'(s + 1)]))) begin
            seg = s;
            break;
         end
      end
      if (seg == 0) begin
         // first quartic runs on absolute time
         dt    = sat_word(t);
         base  = 0;
         terms = 5;
      end else begin
         dt    = sat_word(t - longint'($signed(knot_times[PW'(seg)])));
         base  = 4 * seg + 1;
         terms = (seg == n - 2) ? 5 : 4;
      end
      r.position = ppte_pkg::WORD_W'(horner_sum(base, terms, dt, 1'b0));
      r.velocity = ppte_pkg::WORD_W'(horner_sum(base, terms, dt, 1'b1));
      r.segment  = ppte_pkg::SEG_OUT_W'(seg);
      r.past_end = (t > longint'($signed(knot_times[PW'(n - 1)])));
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Directed items, run with points_in_use at its reset value of 3.
   // Breakpoints 0, 1.0, 2.0; segment 0 is the constant 3.0, segment 1 holds extremes.
   // ---------------------------------------------------------------------------------------
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{ppte_pkg::OP_WR_BREAK, 6'd0,  32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_BREAK, 6'd1,  32'h0001_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_BREAK, 6'd2,  32'h0002_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      // breakpoint index beyond the store: dropped
      '{ppte_pkg::OP_WR_BREAK, 6'd63, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd0,  32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd1,  32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd2,  32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd3,  32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd4,  32'h0003_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd5,  32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd6,  32'h8000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd7,  32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd8,  32'h0000_8000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_WR_COEFF, 6'd9,  32'hFFFF_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      // time zero, on the first breakpoint boundary and mid segment 0: constant 3.0
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0000_0000, 1'b1, 32'h0003_0000, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0001_0000, 1'b1, 32'h0003_0000, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0000_8000, 1'b1, 32'h0003_0000, 32'h0, 4'd0, 1'b0},
      // into the last quartic, exactly on the last breakpoint, and far past the end
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0001_8000, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0002_0000, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      // spare op code: no result
      '{OP_SPARE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      // unsorted breakpoints: segment 0 found, but past the last point
      '{ppte_pkg::OP_WR_BREAK, 6'd1,  32'h0005_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0003_0000, 1'b1, 32'h0003_0000, 32'h0, 4'd0, 1'b1},
      // negative breakpoint: search falls through, offset saturates
      '{ppte_pkg::OP_WR_BREAK, 6'd1,  32'h8000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0},
      '{ppte_pkg::OP_EVAL, 6'd0, 32'h0, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 4'd0, 1'b0}
   };

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic stim_row_type plain_row(input logic [ppte_pkg::OP_W-1:0] op,
                                              input logic [ppte_pkg::INDEX_W-1:0] addr,
                                              input logic [ppte_pkg::WORD_W-1:0] value,
                                              input logic [ppte_pkg::WORD_W-1:0] when);
      stim_row_type r;
      r       = '0;
      r.op    = op;
      r.addr  = addr;
      r.value = value;
      r.when  = when;
      return r;
   endfunction

   // mostly within +-4.0 so that results stay out of saturation, now and then anything
   function automatic logic [ppte_pkg::WORD_W-1:0] random_coeff();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return ppte_pkg::WORD_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
   endfunction

   // queue an expected result behind the ones already waiting
   task automatic expect_sample(input traj_sample_type sample);
      pending_samples = {pending_samples, sample};
   endtask

   // offer one item from a falling edge, wait for acceptance, update the copy of the state
   task automatic send_item(input stim_row_type item);
      traj_sample_type typed_sample;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.op;
      req_tdata  <= {2'b00, item.when, item.value, item.addr};
      do @(posedge clock); while (!req_tready);
      case (item.op)
         ppte_pkg::OP_WR_BREAK: begin
            if (item.addr < MAX_POINTS) knot_times[PW'(item.addr)] = item.value;
         end
         ppte_pkg::OP_WR_COEFF: begin
            if (item.addr < COEFF_DEPTH) poly_coeffs[CW'(item.addr)] = item.value;
         end
         ppte_pkg::OP_EVAL: begin
            if (item.typed) begin
               typed_sample = '{item.pos, item.vel, item.seg, item.past};
               expect_sample(typed_sample);
            end else begin
               expect_sample(predict_trajectory_sample(item.when));
            end
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   // let every result out, then give a trailing write time to settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_points(input logic [ppte_pkg::CSR_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
      active_points = v;
   endtask

   task automatic report_mismatch(input string what, input logic [ppte_pkg::WORD_W-1:0] got,
                                  input logic [ppte_pkg::WORD_W-1:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: reset, directed table, then random phases
   // ---------------------------------------------------------------------------------------
   initial begin : driver
      int unsigned                 n;
      int unsigned                 pick;
      int unsigned                 s;
      logic [ppte_pkg::WORD_W-1:0] lo;
      logic [ppte_pkg::WORD_W-1:0] hi;
      logic [ppte_pkg::WORD_W-1:0] when;
      logic [ppte_pkg::WORD_W-1:0] stamp;
      logic [ppte_pkg::CSR_W-1:0]  setting;
      logic [ppte_pkg::CSR_W-1:0]  phase_points [PHASES];

      // extremes and clamped values; entry 4 is replaced by a random count
      phase_points = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8, 5'd2, 5'd17};

      reset      <= 1'b1;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ppte_pkg::OP_WR_BREAK;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_N; r++) send_item(directed_rows[r]);

      // fill both stores so that no evaluate can touch an entry never written
      for (int i = 0; i < MAX_POINTS; i++)
         send_item(plain_row(ppte_pkg::OP_WR_BREAK, ppte_pkg::INDEX_W'(i),
                             ppte_pkg::WORD_W'(i) << 16, $urandom));
      for (int i = 0; i < COEFF_DEPTH; i++)
         send_item(plain_row(ppte_pkg::OP_WR_COEFF, ppte_pkg::INDEX_W'(i), random_coeff(),
                             $urandom));

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         setting = (phase == 4) ? ppte_pkg::CSR_W'($urandom_range(4, 15))
                                : phase_points[phase];
         set_points(setting);
         n = points_clamped(setting);

         // a fresh trajectory: rising breakpoints, one phase deliberately out of order
         stamp = $urandom_range(0, 32'h0000_8000);
         for (int unsigned i = 0; i < n; i++) begin
            if (phase == 5) begin
               send_item(plain_row(ppte_pkg::OP_WR_BREAK, ppte_pkg::INDEX_W'(i),
                                   $urandom_range(0, 32'h000A_0000), $urandom));
            end else begin
               send_item(plain_row(ppte_pkg::OP_WR_BREAK, ppte_pkg::INDEX_W'(i), stamp,
                                   $urandom));
               stamp = stamp + $urandom_range(32'h0000_1000, 32'h0002_0000);
            end
         end
         for (int unsigned i = 0; i < 4 * n - 2; i++)
            send_item(plain_row(ppte_pkg::OP_WR_COEFF, ppte_pkg::INDEX_W'(i), random_coeff(),
                                $urandom));

         // receiver goes quiet for a long stretch while items keep coming
         if (phase == 0) hold_request = 1'b1;

         for (int j = 0; j < EVALS_PER_PHASE; j++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               send_item(plain_row(OP_SPARE, ppte_pkg::INDEX_W'($urandom), $urandom,
                                   $urandom));
            end else if (pick == 1) begin
               send_item(plain_row(ppte_pkg::OP_WR_BREAK,
                                   ppte_pkg::INDEX_W'($urandom_range(MAX_POINTS, 63)),
                                   $urandom, $urandom));
            end else if (pick == 2) begin
               send_item(plain_row(ppte_pkg::OP_WR_COEFF, ppte_pkg::INDEX_W'($urandom),
                                   random_coeff(), $urandom));
            end else begin
               case ($urandom_range(0, 9))
                  0: when = $urandom;
                  1: when = knot_times[PW'($urandom_range(0, n - 1))];
                  2: when = knot_times[PW'(n - 1)] + $urandom_range(1, 32'h0004_0000);
                  default: begin
                     s  = $urandom_range(0, n - 2);
                     lo = knot_times[PW'(s)];
                     hi = knot_times[PW'(s + 1)];
                     if ($signed(hi) > $signed(lo)) when = lo + $urandom_range(0, hi - lo);
                     else when = lo;
                  end
               endcase
               send_item(plain_row(ppte_pkg::OP_EVAL, ppte_pkg::INDEX_W'($urandom),
                                   $urandom, when));
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("piecewise_poly_trajectory_eval_top test passed");
      end else begin
         $display("piecewise_poly_trajectory_eval_top test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: random stalls, plus the one long hold-off counted here
   // ---------------------------------------------------------------------------------------
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result checker: each accepted item against the oldest expectation
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      traj_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected result, position", rsp_tdata[31:0], '0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata[31:0] !== want.position)
               report_mismatch("position", rsp_tdata[31:0], want.position);
            if (rsp_tdata[63:32] !== want.velocity)
               report_mismatch("velocity", rsp_tdata[63:32], want.velocity);
            if (rsp_tdata[67:64] !== want.segment)
               report_mismatch("segment", ppte_pkg::WORD_W'(rsp_tdata[67:64]),
                               ppte_pkg::WORD_W'(want.segment));
            if (rsp_tuser !== want.past_end)
               report_mismatch("past_end", ppte_pkg::WORD_W'(rsp_tuser),
                               ppte_pkg::WORD_W'(want.past_end));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: too long without any item moving on either side
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("piecewise_poly_trajectory_eval_top test failed");
         $finish;
      end
   end

endmodule
